// ----- src/tnrx_pkg.sv -----
// tnrx_pkg: constants, codes and types shared by the Telnet receive parser.
// Telnet command octets, parser state and event codes, and the decode result word.
// No dependencies.
`timescale 1ns / 1ps

package tnrx_pkg;

  // Telnet command octets
  localparam logic [7:0] IAC  = 8'd255;
  localparam logic [7:0] SB   = 8'd250;
  localparam logic [7:0] SE   = 8'd240;
  localparam logic [7:0] DM   = 8'd242;
  localparam logic [7:0] NOP  = 8'd241;
  localparam logic [7:0] WILL = 8'd251;
  localparam logic [7:0] WONT = 8'd252;
  localparam logic [7:0] DO   = 8'd253;
  localparam logic [7:0] DONT = 8'd254;

  // Item kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_URGENT = 1'b1;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_IAC    = 3'd1,
    ST_OPT    = 3'd2,
    ST_SUB    = 3'd3,
    ST_SUBIAC = 3'd4
  } tnrx_state_t;

  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_SPECIAL = 3'd1,
    EV_OPTION  = 3'd2,
    EV_SUBBYTE = 3'd3,
    EV_SUBEND  = 3'd4
  } tnrx_event_t;

  // One decoded result, with a flag saying whether the word gives one
  typedef struct packed {
    logic        hit;
    tnrx_event_t ev;
    logic [7:0]  value;
    logic [7:0]  verb;
  } tnrx_res_t;

endpackage

// ----- src/tnrx_in_stage.sv -----
// tnrx_in_stage: input register of the Telnet receive parser.
// Holds one received word until the decode stage can pass it on. Uses tnrx_pkg.
`timescale 1ns / 1ps

module tnrx_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       adv,
  output logic       fire,
  output logic       kind,
  output logic [7:0] rx_byte
);
  import tnrx_pkg::*;

  logic       valid_r, valid_nxt;
  logic       kind_r;
  logic [7:0] byte_r;
  logic       load;

  // Stall only while a held word cannot move on
  assign in_stall = valid_r & ~adv;
  assign load     = in_valid & ~in_stall;
  assign fire     = valid_r & adv;
  assign kind     = kind_r;
  assign rx_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  // Control flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= in_kind;
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ----- src/tnrx_decode.sv -----
// tnrx_decode: parser state machine of the Telnet receive parser.
// Decodes one word per cycle unless the output stalls, into at most one result,
// and keeps parse state, synch mode and the saved option verb. Uses tnrx_pkg.
`timescale 1ns / 1ps

module tnrx_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              kind,
  input  logic [7:0]        rx_byte,
  output tnrx_pkg::tnrx_res_t res
);
  import tnrx_pkg::*;

  tnrx_state_t state_r, state_nxt;
  logic        synch_r, synch_nxt;
  logic [7:0]  verb_r, verb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DATA;
      synch_r <= 1'b0;
      verb_r  <= 8'd0;
    end else if (fire) begin
      state_r <= state_nxt;
      synch_r <= synch_nxt;
      verb_r  <= verb_nxt;
    end
  end

  // Next state and result for the word on hand
  always_comb begin
    state_nxt = state_r;
    synch_nxt = synch_r;
    verb_nxt  = verb_r;
    res.hit   = 1'b0;
    res.ev    = EV_DATA;
    res.value = rx_byte;
    res.verb  = 8'd0;
    if (kind == KIND_URGENT) begin
      synch_nxt = 1'b1;
    end else begin
      case (state_r)
        ST_IAC: begin
          state_nxt = ST_DATA;
          if (rx_byte == IAC) begin
            res.hit = ~synch_r;
          end else if (rx_byte == SB) begin
            state_nxt = ST_SUB;
          end else if (rx_byte == NOP) begin
            state_nxt = ST_DATA;
          end else if (rx_byte == DM) begin
            synch_nxt = 1'b0;
          end else if (rx_byte == WILL || rx_byte == WONT ||
                       rx_byte == DO || rx_byte == DONT) begin
            verb_nxt  = rx_byte;
            state_nxt = ST_OPT;
          end else begin
            res.hit = 1'b1;
            res.ev  = EV_SPECIAL;
          end
        end
        ST_OPT: begin
          state_nxt = ST_DATA;
          res.hit   = 1'b1;
          res.ev    = EV_OPTION;
          res.verb  = verb_r;
        end
        ST_SUB: begin
          if (rx_byte == IAC) begin
            state_nxt = ST_SUBIAC;
          end else begin
            res.hit = 1'b1;
            res.ev  = EV_SUBBYTE;
          end
        end
        ST_SUBIAC: begin
          res.hit = 1'b1;
          if (rx_byte == SE) begin
            state_nxt = ST_DATA;
            res.ev    = EV_SUBEND;
            res.value = 8'd0;
          end else begin
            state_nxt = ST_SUB;
            res.ev    = EV_SUBBYTE;
          end
        end
        default: begin
          if (rx_byte == IAC) begin
            state_nxt = ST_IAC;
          end else begin
            state_nxt = ST_DATA;
            res.hit   = ~synch_r;
          end
        end
      endcase
    end
  end

endmodule

// ----- src/telnet_receive_command_parser.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | in_kind, in_rx_byte
// out_    | output    | out_valid/out_stall | out_event_res, out_value, out_option_verb
//
// One word is accepted per cycle while in_stall is low; the word waits in the input register,
// is decoded combinationally and its result is loaded into the output register, where
// out_valid shows it until it is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to the
// data state with synch mode off and the saved verb zero.
// A stall on the output holds the result; one more word waits in the input register,
// then in_stall rises. Words that give no result leave the output untouched.
// Top level: uses tnrx_pkg, tnrx_in_stage and tnrx_decode.
`timescale 1ns / 1ps

module telnet_receive_command_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_value,
  output logic [7:0] out_option_verb
);
  import tnrx_pkg::*;

  logic        adv;
  logic        fire;
  logic        kind;
  logic [7:0]  rx_byte;
  tnrx_res_t   res;

  logic        out_valid_r, out_valid_nxt;
  tnrx_event_t out_ev_r;
  logic [7:0]  out_value_r;
  logic [7:0]  out_verb_r;

  // Move on when the output register is empty or being taken
  assign adv = ~out_valid_r | ~out_stall;

  tnrx_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_rx_byte(in_rx_byte),
    .adv       (adv),
    .fire      (fire),
    .kind      (kind),
    .rx_byte   (rx_byte)
  );

  tnrx_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .kind   (kind),
    .rx_byte(rx_byte),
    .res    (res)
  );

  assign out_valid_nxt = adv ? (fire & res.hit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (adv && fire && res.hit) begin
      out_ev_r    <= res.ev;
      out_value_r <= res.value;
      out_verb_r  <= res.verb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_ev_r;
  assign out_value       = out_value_r;
  assign out_option_verb = out_verb_r;

  // An option request carries one of the four negotiation verbs
  a_opt_verb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r == EV_OPTION) |->
      (out_verb_r == WILL || out_verb_r == WONT || out_verb_r == DO || out_verb_r == DONT))
    else $error("option request without a negotiation verb");

  // Every other event carries a zero verb
  a_verb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r != EV_OPTION) |-> (out_verb_r == 8'd0))
    else $error("verb set on a non-option event");

  // Subnegotiation end carries a zero value
  a_subend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r == EV_SUBEND) |-> (out_value_r == 8'd0))
    else $error("subnegotiation end with non-zero value");

  // Input stalls only while the output holds a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled with the output free");

endmodule

// ----- bench/tnrx_event_checker.sv -----
// tnrx_event_checker: watches both channels of the Telnet receive parser, predicts each
// event from the accepted words and compares it with the result words.
// Depends on tnrx_pkg for the command octets, parser states and event codes.
`timescale 1ns / 1ps

module tnrx_event_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_event_res,
  input  logic [7:0] out_value,
  input  logic [7:0] out_option_verb,
  output int         fail_count,
  output int         pending
);
  import tnrx_pkg::*;

  localparam int MAX_REPORTS = 100;

  // Predicted parser state
  tnrx_state_t parse_st;
  logic        synch;
  logic [7:0]  verb_held;

  // Events still owed by the block, oldest first
  tnrx_res_t   owed_events[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ns  mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    end
  endtask

  // Advance the predicted parser by one word; hit is set when it yields an event
  function automatic tnrx_res_t parse_octet(input logic kind, input logic [7:0] b);
    tnrx_res_t ev;
    ev = '0;
    if (kind == KIND_URGENT) begin
      synch = 1'b1;
      return ev;
    end
    case (parse_st)
      ST_IAC: begin
        parse_st = ST_DATA;
        if (b == IAC) begin
          // doubled IAC is a data octet
          ev.hit   = !synch;
          ev.ev    = EV_DATA;
          ev.value = b;
        end else if (b == SB) begin
          parse_st = ST_SUB;
        end else if (b == DM) begin
          synch = 1'b0;
        end else if (b == WILL || b == WONT || b == DO || b == DONT) begin
          verb_held = b;
          parse_st  = ST_OPT;
        end else if (b != NOP) begin
          ev.hit   = 1'b1;
          ev.ev    = EV_SPECIAL;
          ev.value = b;
        end
      end
      ST_OPT: begin
        parse_st = ST_DATA;
        ev.hit   = 1'b1;
        ev.ev    = EV_OPTION;
        ev.value = b;
        ev.verb  = verb_held;
      end
      ST_SUB: begin
        if (b == IAC) begin
          parse_st = ST_SUBIAC;
        end else begin
          ev.hit   = 1'b1;
          ev.ev    = EV_SUBBYTE;
          ev.value = b;
        end
      end
      ST_SUBIAC: begin
        ev.hit = 1'b1;
        if (b == SE) begin
          parse_st = ST_DATA;
          ev.ev    = EV_SUBEND;
        end else begin
          // escaped octet inside subnegotiation, stay in it
          parse_st = ST_SUB;
          ev.ev    = EV_SUBBYTE;
          ev.value = b;
        end
      end
      default: begin
        if (b == IAC) begin
          parse_st = ST_IAC;
        end else begin
          parse_st = ST_DATA;
          ev.hit   = !synch;
          ev.ev    = EV_DATA;
          ev.value = b;
        end
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk) begin : watch
    tnrx_res_t owed;
    tnrx_res_t fresh;
    if (!rst_n) begin
      parse_st  = ST_DATA;
      synch     = 1'b0;
      verb_held = 8'd0;
      owed_events.delete();
    end else begin
      // compare a delivered word with the oldest owed event
      if (out_valid && !out_stall) begin
        if (owed_events.size() == 0) begin
          report_mismatch("unexpected result word, event code", out_event_res, -1);
        end else begin
          owed = owed_events.pop_front();
          if (out_event_res !== owed.ev) begin
            report_mismatch("event code", out_event_res, owed.ev);
          end
          if (out_value !== owed.value) begin
            report_mismatch("value", out_value, owed.value);
          end
          if (out_option_verb !== owed.verb) begin
            report_mismatch("option verb", out_option_verb, owed.verb);
          end
        end
      end
      // predict from an accepted word
      if (in_valid && !in_stall) begin
        fresh = parse_octet(in_kind, in_rx_byte);
        if (fresh.hit) begin
          owed_events.push_back(fresh);
        end
      end
    end
    pending <= owed_events.size();
  end

endmodule

// ----- bench/testbench.sv -----
// testbench: drives bursts of Telnet words into the receive parser, stalls its results
// on a random pattern with one long hold-off, and gives the verdict.
// Depends on tnrx_pkg, telnet_receive_command_parser and tnrx_event_checker.
`timescale 1ns / 1ps

module testbench;
  import tnrx_pkg::*;

  localparam int WORDS_WANTED = 1650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_event_res;
  logic [7:0] out_value;
  logic [7:0] out_option_verb;

  int fail_count;
  int pending;
  int words_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  telnet_receive_command_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_value       (out_value),
    .out_option_verb (out_option_verb)
  );

  tnrx_event_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_value       (out_value),
    .out_option_verb (out_option_verb),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall results on a changing pattern, with one long hold-off to fill the block
  always @(posedge clk) begin : rx_stall
    int          rx_cycle;
    int          hold_left;
    int          mode_left;
    stall_mode_t stall_mode;
    if (!rst_n) begin
      rx_cycle  = 0;
      hold_left = 0;
      mode_left = 0;
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one word, opening a new burst after a random gap when the last one ran out
  task automatic put_word(input logic kind, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // One random sequence: mostly well-formed Telnet traffic, some noise
  task automatic send_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) put_word(KIND_BYTE, 8'($urandom_range(0, 254)));
    end else if (pick < 43) begin
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, IAC);
    end else if (pick < 58) begin
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, 8'(WILL + $urandom_range(0, 3)));
      put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 66) begin
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      // subnegotiation with the odd escaped octet
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, SB);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          put_word(KIND_BYTE, IAC);
        end
        put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
      end
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, SE);
    end else if (pick < 85) begin
      put_word(KIND_URGENT, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      put_word(KIND_BYTE, IAC);
      put_word(KIND_BYTE, DM);
    end else begin
      put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_BYTE;
    in_rx_byte = 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // plain data extremes
    put_word(KIND_BYTE, 8'h00);
    put_word(KIND_BYTE, 8'hFE);
    // doubled IAC, then a dropped no-op
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, NOP);
    // option requests at both ends of the option range
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, WILL);
    put_word(KIND_BYTE, 8'h00);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, DONT);
    put_word(KIND_BYTE, 8'hFF);
    // SE outside subnegotiation is a special command
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, SE);
    // subnegotiation with an escaped non-SE octet, then its end
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, SB);
    put_word(KIND_BYTE, 8'h01);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, 8'h05);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, SE);
    // urgent notice: data and doubled IAC are swallowed until DM
    put_word(KIND_URGENT, 8'hFF);
    put_word(KIND_BYTE, 8'h41);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, IAC);
    put_word(KIND_BYTE, DM);

    while (words_sent < WORDS_WANTED) begin
      send_sequence();
    end
    in_valid <= 1'b0;

    // drain owed events, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- telnet_receive_command_parser.f -----
src/tnrx_pkg.sv
src/tnrx_in_stage.sv
src/tnrx_decode.sv
src/telnet_receive_command_parser.sv
bench/tnrx_event_checker.sv
bench/testbench.sv
